// ===== rtl/tprs_pkg.sv =====
// Shared types and constants for the timer prescaler and reload search block.
package tprs_pkg;

  // Reset value of the timer clock register
  localparam logic [31:0] TimerClkReset = 32'd108000000;
  // Error value that means no step has been accepted yet
  localparam logic [31:0] ErrNone       = 32'hFFFF_FFFF;
  // Largest reload + 1 a 16-bit reload can express
  localparam logic [31:0] ReloadSpan    = 32'd65536;
  // Last prescaler value of the sweep
  localparam logic [15:0] PscLast       = 16'hFFFF;

  // Divider operand selection codes
  localparam logic [1:0] DivQuot = 2'd0;  // timer clock / (prescaler + 1)
  localparam logic [1:0] DivPer  = 2'd1;  // rounded quotient / target
  localparam logic [1:0] DivHz   = 2'd2;  // quotient / period

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;       // take a new target, restart the sweep
    logic       div_start;  // launch the divider
    logic [1:0] div_sel;    // which division to launch
    logic       update;     // keep the current step as the best one
    logic       next_p;     // advance the prescaler
  } tprs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_done;     // divider result ready and captured
    logic quot_zero;    // clock quotient is zero
    logic period_ok;    // reload + 1 lies in 1..65536
    logic better;       // current error beats the best so far
    logic exact;        // current error is zero
    logic quot_lt_tgt;  // quotient below the target
    logic p_last;       // prescaler at its last value
  } tprs_stat_t;

endpackage

// ===== rtl/tprs_div.sv =====
// Radix-2 restoring divider, 32-bit unsigned, one quotient bit per cycle.
module tprs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;

  // One restoring step: shift in the next dividend bit, try to subtract
  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = ~diff[32];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[31:0] : shifted[31:0];
      quo_d = {quo_q[30:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/tprs_dp.sv =====
// Datapath: sweep registers, shared divider and best-candidate tracking.
module tprs_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tprs_pkg::tprs_cmd_t  cmd_i,
  output tprs_pkg::tprs_stat_t stat_o,
  input  logic [31:0]          timer_clock_hz_i,
  input  logic [31:0]          target_hz_i,
  output logic [15:0]          prescaler_o,
  output logic [15:0]          reload_o,
  output logic [31:0]          actual_hz_o
);

  logic [31:0] target_q;
  logic [15:0] p_q;
  logic [31:0] quot_q;
  logic [31:0] period_q;
  logic [31:0] hz_q;
  logic [1:0]  sel_q;
  logic [31:0] min_err_q;
  logic [15:0] best_psc_q;
  logic [15:0] best_rel_q;
  logic [31:0] best_hz_q;

  logic [31:0] dvd;
  logic [31:0] dvs;
  logic        div_done;
  logic [31:0] div_quo;
  logic [31:0] err;
  logic [15:0] rel_m1;

  // Divider operand select; the rounding sum wraps at 32 bits
  always_comb begin
    case (cmd_i.div_sel)
      tprs_pkg::DivQuot: begin
        dvd = timer_clock_hz_i;
        dvs = {16'd0, p_q} + 32'd1;
      end
      tprs_pkg::DivPer: begin
        dvd = quot_q + {1'b0, target_q[31:1]};
        dvs = target_q;
      end
      tprs_pkg::DivHz: begin
        dvd = quot_q;
        dvs = period_q;
      end
      default: begin
        dvd = quot_q;
        dvs = target_q;
      end
    endcase
  end

  tprs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Absolute error of the current step
  assign err    = (hz_q > target_q) ? (hz_q - target_q) : (target_q - hz_q);
  assign rel_m1 = period_q[15:0] - 16'd1;

  // Item and sweep registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      target_q <= (target_hz_i == 32'd0) ? 32'd1 : target_hz_i;
      p_q      <= '0;
    end else if (cmd_i.next_p) begin
      p_q <= p_q + 16'd1;
    end
    if (cmd_i.div_start) begin
      sel_q <= cmd_i.div_sel;
    end
    // Capture the divider result into the register it was launched for
    if (div_done) begin
      case (sel_q)
        tprs_pkg::DivQuot: quot_q   <= div_quo;
        tprs_pkg::DivPer:  period_q <= div_quo;
        tprs_pkg::DivHz:   hz_q     <= div_quo;
        default:           hz_q     <= div_quo;
      endcase
    end
  end

  // Best candidate so far
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      min_err_q  <= tprs_pkg::ErrNone;
      best_psc_q <= '0;
      best_rel_q <= '0;
      best_hz_q  <= '0;
    end else if (cmd_i.update) begin
      min_err_q  <= err;
      best_psc_q <= p_q;
      best_rel_q <= rel_m1;
      best_hz_q  <= hz_q;
    end
  end

  // Status toward the controller
  assign stat_o.div_done    = div_done;
  assign stat_o.quot_zero   = (quot_q == 32'd0);
  assign stat_o.period_ok   = (period_q != 32'd0) && (period_q <= tprs_pkg::ReloadSpan);
  assign stat_o.better      = (err < min_err_q);
  assign stat_o.exact       = (err == 32'd0);
  assign stat_o.quot_lt_tgt = (quot_q < target_q);
  assign stat_o.p_last      = (p_q == tprs_pkg::PscLast);

  assign prescaler_o = best_psc_q;
  assign reload_o    = best_rel_q;
  assign actual_hz_o = best_hz_q;

endmodule

// ===== rtl/tprs_ctrl.sv =====
// Controller: sequences the up to three divisions of each sweep step and the handshakes.
module tprs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tprs_pkg::tprs_cmd_t  cmd_o,
  input  tprs_pkg::tprs_stat_t stat_i
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SQStart = 4'd1;
  localparam logic [3:0] SQWait  = 4'd2;
  localparam logic [3:0] SPStart = 4'd3;
  localparam logic [3:0] SPWait  = 4'd4;
  localparam logic [3:0] SHStart = 4'd5;
  localparam logic [3:0] SHWait  = 4'd6;
  localparam logic [3:0] SEval   = 4'd7;
  localparam logic [3:0] SOut    = 4'd8;

  logic [3:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.div_sel    = tprs_pkg::DivQuot;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SQStart;
        end
      end
      SQStart: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = tprs_pkg::DivQuot;
        state_d         = SQWait;
      end
      SQWait: begin
        if (stat_i.div_done) begin
          state_d = SPStart;
        end
      end
      SPStart: begin
        if (stat_i.quot_zero) begin
          state_d = SOut;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = tprs_pkg::DivPer;
          state_d         = SPWait;
        end
      end
      SPWait: begin
        if (stat_i.div_done) begin
          state_d = SHStart;
        end
      end
      SHStart: begin
        // Reload out of range: skip this prescaler, no early stop
        if (!stat_i.period_ok) begin
          if (stat_i.p_last) begin
            state_d = SOut;
          end else begin
            cmd_o.next_p = 1'b1;
            state_d      = SQStart;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = tprs_pkg::DivHz;
          state_d         = SHWait;
        end
      end
      SHWait: begin
        if (stat_i.div_done) begin
          state_d = SEval;
        end
      end
      SEval: begin
        cmd_o.update = stat_i.better;
        if ((stat_i.better && stat_i.exact) || stat_i.quot_lt_tgt || stat_i.p_last) begin
          state_d = SOut;
        end else begin
          cmd_o.next_p = 1'b1;
          state_d      = SQStart;
        end
      end
      SOut: begin
        if (out_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);

endmodule

// ===== rtl/timer_prescaler_reload_search_top.sv =====
// Top level of the timer prescaler and reload search block.
// Give it a target frequency beat and it returns one result beat with the 16-bit
// prescaler and reload pair whose output frequency timer_clock_hz /
// ((prescaler+1) * (reload+1)) is closest to the target, plus the frequency that
// pair achieves; a target of zero counts as one, and an all-zero result means no
// pair fit (this includes a timer clock of zero). The prescaler is swept upward
// from zero; each sweep step runs up to three 32-bit divisions on one shared
// radix-2 divider that retires one quotient bit per cycle. The sweep ends early on
// a zero quotient, an exact match or, when the reload is in range, a quotient
// below the target. One item is in flight at a time; write timer_clock_hz only
// while no item is pending.
module timer_prescaler_reload_search_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // Target beat
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] target_hz_i,
  // Result beat
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] prescaler_o,
  output logic [15:0] reload_o,
  output logic [31:0] actual_hz_o
);

  logic [31:0]          timer_clock_hz_q;
  tprs_pkg::tprs_cmd_t  cmd;
  tprs_pkg::tprs_stat_t stat;

  // Timer clock register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_clock_hz_q <= tprs_pkg::TimerClkReset;
    end else if (cfg_we_i) begin
      timer_clock_hz_q <= cfg_wdata_i;
    end
  end

  tprs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  tprs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .timer_clock_hz_i (timer_clock_hz_q),
    .target_hz_i      (target_hz_i),
    .prescaler_o      (prescaler_o),
    .reload_o         (reload_o),
    .actual_hz_o      (actual_hz_o)
  );

  // An accepted target never yields a result in the very next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("result beat right after target accept");

  // The divider is never relaunched while it reports a finished result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_done |-> !cmd.div_start)
    else $error("divider relaunched on done");

  // A zero achieved frequency only comes with the all-zero no-fit result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && actual_hz_o == 32'd0) |-> (prescaler_o == 16'd0 && reload_o == 16'd0))
    else $error("zero frequency with nonzero pair");

  // Best candidate is only updated on a step that improves the error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update |-> (stat.better && stat.period_ok && !stat.quot_zero))
    else $error("best candidate updated on an invalid step");

endmodule
